/* design/assert_macros.svh */
// Shared assertion macros for the index decoder checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge while reset is released.
`define TVID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define TVID_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* design/tvid_pkg.sv */
`default_nettype none

package tvid_pkg;

  // Field and state widths.
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int GROUP_W = 6;
  localparam int VALUE_W = 19;
  localparam int CNT_W   = 2;

  // Lead byte form patterns, applied to bits 5:0.
  localparam logic [GROUP_W-1:0] ONE_MASK   = 6'h20;
  localparam logic [GROUP_W-1:0] ONE_CODE   = 6'h00;
  localparam logic [GROUP_W-1:0] TWO_MASK   = 6'h38;
  localparam logic [GROUP_W-1:0] TWO_CODE   = 6'h30;
  localparam logic [GROUP_W-1:0] THREE_MASK = 6'h3C;
  localparam logic [GROUP_W-1:0] THREE_CODE = 6'h38;
  localparam logic [GROUP_W-1:0] FOUR_MASK  = 6'h3E;
  localparam logic [GROUP_W-1:0] FOUR_CODE  = 6'h3C;

  // Continuation bytes still expected after each lead form.
  localparam logic [CNT_W-1:0] MORE_NONE  = 2'd0;
  localparam logic [CNT_W-1:0] MORE_ONE   = 2'd1;
  localparam logic [CNT_W-1:0] MORE_TWO   = 2'd2;
  localparam logic [CNT_W-1:0] MORE_THREE = 2'd3;

  typedef enum logic [2:0] {
    FORM_ONE,
    FORM_TWO,
    FORM_THREE,
    FORM_FOUR,
    FORM_BAD
  } tvid_form_e;

  // One decoded result.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               bad;
  } tvid_res_t;

  // Classify the low six bits of a lead byte.
  function automatic tvid_form_e tvid_classify(input logic [GROUP_W-1:0] grp);
    tvid_form_e form;
    priority if ((grp & ONE_MASK) == ONE_CODE) begin
      form = FORM_ONE;
    end else if ((grp & TWO_MASK) == TWO_CODE) begin
      form = FORM_TWO;
    end else if ((grp & THREE_MASK) == THREE_CODE) begin
      form = FORM_THREE;
    end else if ((grp & FOUR_MASK) == FOUR_CODE) begin
      form = FORM_FOUR;
    end else begin
      form = FORM_BAD;
    end
    return form;
  endfunction

endpackage

`default_nettype wire

/* design/tvid_if.sv */
`default_nettype none

// Byte stream channel.
interface tvid_byte_if import tvid_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink   (input valid, input code_byte, output ready);
endinterface

// Decoded index channel.
interface tvid_result_if import tvid_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  index_kind;
  logic [VALUE_W-1:0] index_value;
  logic               bad_lead;

  modport source (output valid, output index_kind, output index_value, output bad_lead,
                  input ready);
  modport sink   (input valid, input index_kind, input index_value, input bad_lead,
                  output ready);
endinterface

`default_nettype wire

/* design/tvid_in_stage.sv */
`default_nettype none

module tvid_in_stage import tvid_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire logic [BYTE_W-1:0] byte_i,
  output logic                   ready_o,
  output logic                   valid_o,
  output logic [BYTE_W-1:0]      byte_o,
  input  wire logic              consume_i
);

  logic              valid_q;
  logic [BYTE_W-1:0] byte_q;

  // The register takes a new byte when empty or when its byte moves on.
  assign ready_o = !valid_q || consume_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

/* design/tvid_decode.sv */
`default_nettype none

module tvid_decode import tvid_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire logic [BYTE_W-1:0] byte_i,
  input  wire logic              take_i,
  output logic                   consume_o,
  output logic                   emit_o,
  output tvid_res_t              res_o
);

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic [KIND_W-1:0]  tag;
  logic [GROUP_W-1:0] grp;
  logic [VALUE_W-1:0] acc;
  tvid_form_e         form;

  assign tag       = byte_i[BYTE_W-1:GROUP_W];
  assign grp       = byte_i[GROUP_W-1:0];
  assign form      = tvid_classify(grp);
  assign acc       = {val_q[VALUE_W-GROUP_W-1:0], grp};
  assign consume_o = valid_i && take_i;

  // Decode one byte against the index in progress.
  always_comb begin
    cnt_d  = cnt_q;
    val_d  = val_q;
    kind_d = kind_q;
    emit_o = 1'b0;
    res_o  = '0;
    if (valid_i) begin
      if (cnt_q != MORE_NONE) begin
        // Continuation byte: shift in six more value bits.
        emit_o      = (cnt_q == MORE_ONE);
        res_o.kind  = kind_q;
        res_o.value = acc;
        if (consume_o) begin
          val_d = acc;
          cnt_d = cnt_q - MORE_ONE;
        end
      end else begin
        res_o.kind = tag;
        unique case (form)
          FORM_ONE: begin
            emit_o      = 1'b1;
            res_o.value = VALUE_W'(grp[4:0]);
          end
          FORM_TWO: begin
            if (consume_o) begin
              kind_d = tag;
              val_d  = VALUE_W'(grp[2:0]);
              cnt_d  = MORE_ONE;
            end
          end
          FORM_THREE: begin
            if (consume_o) begin
              kind_d = tag;
              val_d  = VALUE_W'(grp[1:0]);
              cnt_d  = MORE_TWO;
            end
          end
          FORM_FOUR: begin
            if (consume_o) begin
              kind_d = tag;
              val_d  = VALUE_W'(grp[0]);
              cnt_d  = MORE_THREE;
            end
          end
          default: begin
            // Invalid lead form reports an error with a zero value.
            emit_o    = 1'b1;
            res_o.bad = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= MORE_NONE;
      val_q  <= '0;
      kind_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      val_q  <= val_d;
      kind_q <= kind_d;
    end
  end

endmodule

`default_nettype wire

/* design/tvid_out_stage.sv */
`default_nettype none

module tvid_out_stage import tvid_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  input  wire tvid_res_t res_i,
  output logic           take_o,
  output logic           valid_o,
  output tvid_res_t      res_o,
  input  wire logic      ready_i
);

  logic      valid_q;
  tvid_res_t res_q;

  // A slot is free when empty or when its result leaves this cycle.
  assign take_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && take_o) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

/* design/tagged_varint_index_decoder.sv */
// Channel    Direction  Transaction
// code_i     in         one instruction byte (code_byte)
// result_o   out        one decoded index (index_kind, index_value, bad_lead)
//
// Each byte passes an input register, combinational decode logic and a result
// register: the result of an index is registered from its completing byte.
// One byte is taken every cycle while results flow; the decode state is a
// continuation counter, the held kind tag and the accumulated value.
// Reset clears the valid flags and the decode state, so the next byte is a lead.
// A stalled result holds both registers; ready falls only while both are full.
`default_nettype none

module tagged_varint_index_decoder import tvid_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  tvid_byte_if.sink      code_i,
  tvid_result_if.source  result_o
);

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              consume;
  logic              take;
  logic              emit;
  tvid_res_t         dec_res;
  tvid_res_t         out_res;

  tvid_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (code_i.valid),
    .byte_i    (code_i.code_byte),
    .ready_o   (code_i.ready),
    .valid_o   (in_valid),
    .byte_o    (in_byte),
    .consume_i (consume)
  );

  tvid_decode u_dec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid),
    .byte_i    (in_byte),
    .take_i    (take),
    .consume_o (consume),
    .emit_o    (emit),
    .res_o     (dec_res)
  );

  tvid_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (emit),
    .res_i   (dec_res),
    .take_o  (take),
    .valid_o (result_o.valid),
    .res_o   (out_res),
    .ready_i (result_o.ready)
  );

  assign result_o.index_kind  = out_res.kind;
  assign result_o.index_value = out_res.value;
  assign result_o.bad_lead    = out_res.bad;

endmodule

`default_nettype wire

/* design/tvid_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module tvid_checker import tvid_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic [KIND_W-1:0]  out_kind_i,
  input wire logic [VALUE_W-1:0] out_value_i,
  input wire logic               out_bad_i
);

  // A stalled result keeps its valid.
  `TVID_ASSERT(a_valid_held, out_valid_i && !out_ready_i |=> out_valid_i, "result valid dropped")

  // A stalled result keeps its payload.
  `TVID_ASSERT(a_payload_held, out_valid_i && !out_ready_i |=> $stable({out_kind_i, out_value_i, out_bad_i}), "result payload changed")

  // An invalid lead form always reports a zero value.
  `TVID_ASSERT(a_bad_zero, out_valid_i && out_bad_i |-> out_value_i == '0, "error result carries a value")

  // No result is offered right after reset.
  `TVID_ASSERT_ALWAYS(a_reset_quiet, !$past(rst_ni) |-> !out_valid_i, "result valid after reset")

endmodule

bind tagged_varint_index_decoder tvid_checker u_tvid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_kind_i  (result_o.index_kind),
  .out_value_i (result_o.index_value),
  .out_bad_i   (result_o.bad_lead)
);

`default_nettype wire

/* tb/tvid_index_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the index decoder, predicts the decoded indices
// from the accepted bytes, and compares each accepted result in order.
module tvid_index_checker import tvid_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tvid_byte_if      code_i,
  tvid_result_if    result_i,
  output int        mismatch_count_o,
  output int        pending_count_o
);

  // Predicted decode state.
  logic [CNT_W-1:0]   bytes_left;
  logic [VALUE_W-1:0] partial_value;
  logic [KIND_W-1:0]  open_kind;

  // Indices predicted but not yet seen on the result channel.
  tvid_res_t expected_indices [$];
  tvid_res_t predicted;
  tvid_res_t oldest;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: index check: %s", $time, msg);
    mismatch_count_o++;
  endtask

  // Advances the predicted state by one byte; returns 1 when an index completes
  // or a lead byte is rejected, with the decoded index in idx.
  function automatic bit decode_code_byte(input logic [BYTE_W-1:0] b, output tvid_res_t idx);
    logic [KIND_W-1:0]  kind;
    logic [GROUP_W-1:0] grp;
    idx  = '0;
    kind = b[BYTE_W-1:GROUP_W];
    grp  = b[GROUP_W-1:0];

    // A continuation byte shifts in its low six bits, whatever its top bits are.
    if (bytes_left != MORE_NONE) begin
      partial_value = {partial_value[VALUE_W-GROUP_W-1:0], grp};
      bytes_left    = bytes_left - 1'b1;
      if (bytes_left == MORE_NONE) begin
        idx.kind  = open_kind;
        idx.value = partial_value;
        idx.bad   = 1'b0;
        return 1'b1;
      end
      return 1'b0;
    end

    // Lead byte: pick the form from the low six bits.
    if ((grp & ONE_MASK) == ONE_CODE) begin
      idx.kind  = kind;
      idx.value = VALUE_W'(grp & ~ONE_MASK);
      idx.bad   = 1'b0;
      return 1'b1;
    end
    if ((grp & TWO_MASK) == TWO_CODE) begin
      open_kind     = kind;
      partial_value = VALUE_W'(grp & ~TWO_MASK);
      bytes_left    = MORE_ONE;
      return 1'b0;
    end
    if ((grp & THREE_MASK) == THREE_CODE) begin
      open_kind     = kind;
      partial_value = VALUE_W'(grp & ~THREE_MASK);
      bytes_left    = MORE_TWO;
      return 1'b0;
    end
    if ((grp & FOUR_MASK) == FOUR_CODE) begin
      open_kind     = kind;
      partial_value = VALUE_W'(grp & ~FOUR_MASK);
      bytes_left    = MORE_THREE;
      return 1'b0;
    end

    // Invalid lead form: raw kind, value fixed at zero.
    idx.kind  = kind;
    idx.value = '0;
    idx.bad   = 1'b1;
    return 1'b1;
  endfunction

  // Compare results first, then predict from the byte taken on the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left    = MORE_NONE;
      partial_value = '0;
      open_kind     = '0;
      expected_indices.delete();
      mismatch_count_o = 0;
      pending_count_o <= 0;
    end else begin
      if (result_i.valid && result_i.ready) begin
        if (expected_indices.size() == 0) begin
          report_mismatch($sformatf("unexpected index: kind %0d value 0x%0h bad %0b",
                                    result_i.index_kind, result_i.index_value,
                                    result_i.bad_lead));
        end else begin
          oldest = expected_indices.pop_front();
          if (result_i.index_kind !== oldest.kind) begin
            report_mismatch($sformatf("index_kind %0d, expected %0d",
                                      result_i.index_kind, oldest.kind));
          end
          if (result_i.index_value !== oldest.value) begin
            report_mismatch($sformatf("index_value 0x%0h, expected 0x%0h",
                                      result_i.index_value, oldest.value));
          end
          if (result_i.bad_lead !== oldest.bad) begin
            report_mismatch($sformatf("bad_lead %0b, expected %0b",
                                      result_i.bad_lead, oldest.bad));
          end
        end
      end
      if (code_i.valid && code_i.ready) begin
        if (decode_code_byte(code_i.code_byte, predicted)) begin
          expected_indices.push_back(predicted);
        end
      end
      pending_count_o <= expected_indices.size();
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

// Drives the index decoder with a byte stream of directed and random
// indices, with random stalls on both channels, and gives the verdict.
module testbench;
  import tvid_pkg::*;

  localparam int ITEM_TARGET   = 550;
  localparam int CALM_FROM     = 470;
  localparam int PAUSE_AT      = 250;
  localparam int DRAIN_CYCLES  = 8;
  localparam int STALL_LIMIT   = 400;

  // Invalid lead forms: 10xxxx and 11111x.
  localparam logic [GROUP_W-1:0] GAP_MASK = 6'h30;
  localparam logic [GROUP_W-1:0] GAP_CODE = 6'h20;
  localparam logic [GROUP_W-1:0] TOP_MASK = 6'h3E;
  localparam logic [GROUP_W-1:0] TOP_CODE = 6'h3E;

  logic clk;
  logic rst_n;
  bit   calm;
  bit   steady;
  int   bytes_sent;
  int   idle_cycles = 0;
  int   mismatches;
  int   pending;

  tvid_byte_if   code_ch ();
  tvid_result_if result_ch ();

  tagged_varint_index_decoder u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .code_i   (code_ch),
    .result_o (result_ch)
  );

  tvid_index_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .code_i           (code_ch),
    .result_i         (result_ch),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sends one byte, with an occasional idle burst ahead of it.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (!calm && !steady && $urandom_range(0, 5) == 0) begin
      code_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    code_ch.valid     <= 1'b1;
    code_ch.code_byte <= b;
    do @(posedge clk); while (!code_ch.ready);
    bytes_sent++;
  endtask

  // Sends one random index: mostly well-formed, some bad leads and noise.
  task automatic send_index();
    logic [31:0]        r;
    logic [KIND_W-1:0]  kind;
    logic [GROUP_W-1:0] form_mask;
    logic [GROUP_W-1:0] form_code;
    int                 sel;
    int                 more;
    r    = $urandom;
    sel  = $urandom_range(0, 99);
    kind = KIND_W'($urandom_range(0, 3));
    more = 0;
    if (sel < 30) begin
      form_mask = ONE_MASK;
      form_code = ONE_CODE;
    end else if (sel < 50) begin
      form_mask = TWO_MASK;
      form_code = TWO_CODE;
      more = 1;
    end else if (sel < 68) begin
      form_mask = THREE_MASK;
      form_code = THREE_CODE;
      more = 2;
    end else if (sel < 85) begin
      form_mask = FOUR_MASK;
      form_code = FOUR_CODE;
      more = 3;
    end else if (sel < 89) begin
      form_mask = GAP_MASK;
      form_code = GAP_CODE;
    end else if (sel < 92) begin
      form_mask = TOP_MASK;
      form_code = TOP_CODE;
    end else begin
      // Noise: any byte at all.
      form_mask = '0;
      form_code = '0;
    end
    send_byte({kind, form_code | (r[GROUP_W-1:0] & ~form_mask)});
    repeat (more) send_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  // Result side: ready with random stall bursts, none near the end.
  initial begin
    forever begin
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!calm) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((code_ch.valid && code_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("tagged_varint_index_decoder test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus.
  initial begin
    logic [BYTE_W-1:0] opening [$];
    bit                paused;
    // Short forms at both ends, bad leads, every multi-byte form, and
    // continuation bytes that look like lead bytes.
    opening = {8'h00, 8'hDF, 8'h20, 8'hAF, 8'h7E, 8'hFF,
               8'h77, 8'hFF,
               8'hBB, 8'hC0, 8'h3F,
               8'hFD, 8'hFF, 8'hFF, 8'hFF,
               8'h3C, 8'h00, 8'h80, 8'h40,
               8'h30, 8'hE0};
    paused      = 1'b0;
    calm        = 1'b0;
    steady      = 1'b0;
    bytes_sent  = 0;
    rst_n       = 1'b0;
    code_ch.valid     <= 1'b0;
    code_ch.code_byte <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening[i]) send_byte(opening[i]);

    while (bytes_sent < ITEM_TARGET) begin
      if (bytes_sent % 50 < 4) begin
        steady = ($urandom_range(0, 2) == 0);
      end
      if (bytes_sent >= CALM_FROM) begin
        calm = 1'b1;
      end
      // Hold off once until every predicted index has come out.
      if (!paused && bytes_sent >= PAUSE_AT) begin
        paused = 1'b1;
        code_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      send_index();
    end

    code_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tagged_varint_index_decoder test passed");
    end else begin
      $display("tagged_varint_index_decoder test failed");
    end
    $finish;
  end

endmodule
